### src/tarsm_pkg.sv
// Shared constants for the tablet area rotate/scale map.
// Register indexes, fixed-point widths and reset values; no dependencies.
package tarsm_pkg;

	localparam int FRAC_BITS = 16;

	localparam int COORD_W = 16;
	localparam int REG_W   = 32;
	localparam int TRIG_W  = 18;
	localparam int IDX_W   = 3;
	localparam int MODE_W  = 3;

	// Offset from centre: 16-bit raw minus (16-bit origin + 15-bit half size).
	localparam int DIFF_W = COORD_W + 2;
	localparam int PROD_W = DIFF_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int ASR_W  = SUM_W - FRAC_BITS;
	localparam int REL_W  = ((ASR_W > COORD_W) ? ASR_W : COORD_W + 1) + 1;
	localparam int MUL_A_W = (REL_W > FRAC_BITS - 1) ? REL_W : FRAC_BITS - 1;
	localparam int MUL_B_W = REG_W + 1;
	localparam int SPROD_W = MUL_A_W + MUL_B_W;

	localparam logic [IDX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [IDX_W-1:0] REG_AREA_SIZE     = 3'd1;
	localparam logic [IDX_W-1:0] REG_AREA_ORIGIN   = 3'd2;
	localparam logic [IDX_W-1:0] REG_SIN_VALUE     = 3'd3;
	localparam logic [IDX_W-1:0] REG_COS_VALUE     = 3'd4;
	localparam logic [IDX_W-1:0] REG_SCALE_X       = 3'd5;
	localparam logic [IDX_W-1:0] REG_SCALE_Y       = 3'd6;
	localparam logic [IDX_W-1:0] REG_SCREEN_ORIGIN = 3'd7;

	localparam int MODE_PASS  = 0;
	localparam int MODE_LIMIT = 1;
	localparam int MODE_CLIP  = 2;

	localparam logic [TRIG_W-1:0] COS_RESET   = TRIG_W'(1 << FRAC_BITS);
	localparam logic [REG_W-1:0]  SCALE_RESET = REG_W'(1 << FRAC_BITS);

	typedef logic signed [REL_W-1:0] rel_t;

endpackage

### src/tablet_area_rotate_scale_map.sv
// Top level of the tablet area rotate/scale map: config registers and a
// six-stage mapping pipeline. Depends on tarsm_pkg.
//
// Usage:
//   Configure through cfg_wr_en / cfg_addr / cfg_wdata while no point is in
//   flight; a write lands at the rising edge where cfg_wr_en is high.
//   Present a raw pen point on raw_x / raw_y with start high; the transfer
//   happens at any rising edge where start is high and busy is low. busy
//   stays low: the pipeline takes a new point every cycle.
//   Each point produces exactly one result, registered in the output stage:
//   done is high for one cycle with accepted, screen_x and screen_y.
//   accepted low means the point fell outside the area with limiting on;
//   the coordinates are then zero.
//   Throughput is one point per cycle. The stages, in order, are the
//   offset from centre, four rotation products, sum and shift, limit/clamp,
//   scale product, origin add and output select.
//   The receiver has no stall path, so results leave as they are made.
//   Reset clears all valid bits and returns the registers to identity
//   mapping values (cosine 1.0, scale 1.0, everything else zero).
module tablet_area_rotate_scale_map
	import tarsm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [IDX_W-1:0]         cfg_addr,
	input  logic [REG_W-1:0]         cfg_wdata,
	input  logic                     start,
	output logic                     busy,
	input  logic [COORD_W-1:0]       raw_x,
	input  logic [COORD_W-1:0]       raw_y,
	output logic                     done,
	output logic                     accepted,
	output logic signed [REG_W-1:0]  screen_x,
	output logic signed [REG_W-1:0]  screen_y
);

	// Configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [REG_W-1:0]  area_size_q;
	logic [REG_W-1:0]  area_origin_q;
	logic [TRIG_W-1:0] sin_q;
	logic [TRIG_W-1:0] cos_q;
	logic [REG_W-1:0]  scale_x_q;
	logic [REG_W-1:0]  scale_y_q;
	logic [REG_W-1:0]  screen_origin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= '0;
			area_size_q     <= '0;
			area_origin_q   <= '0;
			sin_q           <= '0;
			cos_q           <= COS_RESET;
			scale_x_q       <= SCALE_RESET;
			scale_y_q       <= SCALE_RESET;
			screen_origin_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MODE:          mode_q          <= cfg_wdata[MODE_W-1:0];
				REG_AREA_SIZE:     area_size_q     <= cfg_wdata;
				REG_AREA_ORIGIN:   area_origin_q   <= cfg_wdata;
				REG_SIN_VALUE:     sin_q           <= cfg_wdata[TRIG_W-1:0];
				REG_COS_VALUE:     cos_q           <= cfg_wdata[TRIG_W-1:0];
				REG_SCALE_X:       scale_x_q       <= cfg_wdata;
				REG_SCALE_Y:       scale_y_q       <= cfg_wdata;
				REG_SCREEN_ORIGIN: screen_origin_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decoded configuration fields
	logic [COORD_W-1:0] area_w, area_h, half_w, half_h;
	logic [COORD_W-1:0] org_x, org_y;
	logic signed [TRIG_W-1:0] sin_s, cos_s;
	rel_t area_w_ext, area_h_ext, half_w_ext, half_h_ext;

	assign area_w = area_size_q[COORD_W-1:0];
	assign area_h = area_size_q[REG_W-1:COORD_W];
	assign half_w = area_w >> 1;
	assign half_h = area_h >> 1;
	assign org_x  = area_origin_q[COORD_W-1:0];
	assign org_y  = area_origin_q[REG_W-1:COORD_W];
	assign sin_s  = $signed(sin_q);
	assign cos_s  = $signed(cos_q);
	assign area_w_ext = $signed({{(REL_W-COORD_W){1'b0}}, area_w});
	assign area_h_ext = $signed({{(REL_W-COORD_W){1'b0}}, area_h});
	assign half_w_ext = $signed({{(REL_W-COORD_W){1'b0}}, half_w});
	assign half_h_ext = $signed({{(REL_W-COORD_W){1'b0}}, half_h});

	logic accept_in;
	assign busy      = 1'b0;
	assign accept_in = start && !busy;

	// Valid bits travel with the data
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: offset from the area centre; flag passthrough
	logic [COORD_W-1:0] raw_x_s1, raw_y_s1;
	logic byp_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;

	// Stage 2: rotation products
	logic [COORD_W-1:0] raw_x_s2, raw_y_s2;
	logic byp_s2;
	logic signed [PROD_W-1:0] dxc_s2, dys_s2, dyc_s2, dxs_s2;

	// Stage 3: rotated position relative to the area corner
	logic [COORD_W-1:0] raw_x_s3, raw_y_s3;
	logic byp_s3;
	rel_t relx_s3, rely_s3;

	// Stage 4: limit and clamp
	logic [COORD_W-1:0] raw_x_s4, raw_y_s4;
	logic byp_s4, keep_s4;
	rel_t relx_s4, rely_s4;

	// Stage 5: scale products
	logic [COORD_W-1:0] raw_x_s5, raw_y_s5;
	logic byp_s5, keep_s5;
	logic signed [SPROD_W-1:0] px_s5, py_s5;

	// Stage 6: output register
	logic byp_s6, keep_s6;
	logic [REG_W-1:0] sx_s6, sy_s6;

	logic signed [SUM_W-1:0] sum_x, sum_y;
	rel_t rot_x, rot_y;
	logic out_x, out_y;
	rel_t clip_x, clip_y;
	logic signed [MUL_A_W-1:0] mul_ax, mul_ay;
	logic signed [REG_W-1:0] off_x, off_y;

	always_comb begin
		sum_x = {dxc_s2[PROD_W-1], dxc_s2} + {dys_s2[PROD_W-1], dys_s2};
		sum_y = {dyc_s2[PROD_W-1], dyc_s2} - {dxs_s2[PROD_W-1], dxs_s2};
		// Arithmetic shift right by the fraction width, then widen
		rot_x = $signed({{(REL_W-ASR_W){sum_x[SUM_W-1]}}, sum_x[SUM_W-1:FRAC_BITS]});
		rot_y = $signed({{(REL_W-ASR_W){sum_y[SUM_W-1]}}, sum_y[SUM_W-1:FRAC_BITS]});

		out_x = relx_s3[REL_W-1] || (relx_s3 > area_w_ext);
		out_y = rely_s3[REL_W-1] || (rely_s3 > area_h_ext);
		clip_x = relx_s3;
		clip_y = rely_s3;
		if (mode_q[MODE_CLIP]) begin
			if (relx_s3[REL_W-1])
				clip_x = '0;
			else if (relx_s3 > area_w_ext)
				clip_x = area_w_ext;
			if (rely_s3[REL_W-1])
				clip_y = '0;
			else if (rely_s3 > area_h_ext)
				clip_y = area_h_ext;
		end

		mul_ax = MUL_A_W'(relx_s4);
		mul_ay = MUL_A_W'(rely_s4);

		off_x = $signed({{(REG_W-COORD_W){screen_origin_q[COORD_W-1]}},
			screen_origin_q[COORD_W-1:0]});
		off_y = $signed({{(REG_W-COORD_W){screen_origin_q[REG_W-1]}},
			screen_origin_q[REG_W-1:COORD_W]});
	end

	always_ff @(posedge clk) begin
		raw_x_s1 <= raw_x;
		raw_y_s1 <= raw_y;
		byp_s1   <= mode_q[MODE_PASS] || (area_w == '0) || (area_h == '0);
		dx_s1    <= $signed({2'b00, raw_x}) - $signed({2'b00, org_x} + {2'b00, half_w});
		dy_s1    <= $signed({2'b00, raw_y}) - $signed({2'b00, org_y} + {2'b00, half_h});

		raw_x_s2 <= raw_x_s1;
		raw_y_s2 <= raw_y_s1;
		byp_s2   <= byp_s1;
		dxc_s2   <= dx_s1 * cos_s;
		dys_s2   <= dy_s1 * sin_s;
		dyc_s2   <= dy_s1 * cos_s;
		dxs_s2   <= dx_s1 * sin_s;

		raw_x_s3 <= raw_x_s2;
		raw_y_s3 <= raw_y_s2;
		byp_s3   <= byp_s2;
		relx_s3  <= rot_x + half_w_ext;
		rely_s3  <= rot_y + half_h_ext;

		raw_x_s4 <= raw_x_s3;
		raw_y_s4 <= raw_y_s3;
		byp_s4   <= byp_s3;
		// Limiting wins over clamping
		keep_s4  <= !(mode_q[MODE_LIMIT] && (out_x || out_y));
		relx_s4  <= clip_x;
		rely_s4  <= clip_y;

		raw_x_s5 <= raw_x_s4;
		raw_y_s5 <= raw_y_s4;
		byp_s5   <= byp_s4;
		keep_s5  <= keep_s4;
		px_s5    <= mul_ax * $signed({1'b0, scale_x_q});
		py_s5    <= mul_ay * $signed({1'b0, scale_y_q});

		byp_s6   <= byp_s5;
		keep_s6  <= keep_s5;
		if (byp_s5) begin
			sx_s6 <= {{(REG_W-COORD_W){1'b0}}, raw_x_s5};
			sy_s6 <= {{(REG_W-COORD_W){1'b0}}, raw_y_s5};
		end else if (!keep_s5) begin
			sx_s6 <= '0;
			sy_s6 <= '0;
		end else begin
			sx_s6 <= px_s5[FRAC_BITS+REG_W-1:FRAC_BITS] + off_x;
			sy_s6 <= py_s5[FRAC_BITS+REG_W-1:FRAC_BITS] + off_y;
		end
	end

	assign done     = v_s6;
	assign accepted = byp_s6 || keep_s6;
	assign screen_x = $signed(sx_s6);
	assign screen_y = $signed(sy_s6);

	// A result only follows an item in the stage before it
	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s5))
		else $error("result without an item in the scale stage");

	// A dropped point carries zero coordinates
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> (screen_x == '0 && screen_y == '0))
		else $error("dropped point with nonzero coordinates");

	// Passthrough results are accepted raw 16-bit values
	a_pass_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(done && byp_s6) |-> (accepted && sx_s6[REG_W-1:COORD_W] == '0
			&& sy_s6[REG_W-1:COORD_W] == '0))
		else $error("passthrough result is not a raw coordinate");

endmodule

### bench/tb_tablet_area_rotate_scale_map.sv
// Self-checking bench for tablet_area_rotate_scale_map: directed corner points, then
// random register settings with random points and random idle gaps.
// Depends on tarsm_pkg and the block's RTL; reads no files.
module tb_tablet_area_rotate_scale_map;
	import tarsm_pkg::*;

	// Pipeline is six stages deep; leave a little extra before touching registers.
	localparam int PIPE_SLACK  = 10;
	localparam int RAND_PHASES = 12;

	// Mode bit masks built from the package bit positions.
	localparam logic [MODE_W-1:0] M_NONE  = '0;
	localparam logic [MODE_W-1:0] M_PASS  = MODE_W'(1 << MODE_PASS);
	localparam logic [MODE_W-1:0] M_LIMIT = MODE_W'(1 << MODE_LIMIT);
	localparam logic [MODE_W-1:0] M_CLIP  = MODE_W'(1 << MODE_CLIP);

	// Q16.16 helpers for readable directed settings.
	localparam logic [REG_W-1:0] ONE_Q     = REG_W'(1 << FRAC_BITS);
	localparam logic [REG_W-1:0] MINUS_ONE = -ONE_Q;

	typedef struct packed {
		logic             accepted;
		logic [REG_W-1:0] sx;
		logic [REG_W-1:0] sy;
	} screen_pt_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [IDX_W-1:0]        cfg_addr;
	logic [REG_W-1:0]        cfg_wdata;
	logic                    start;
	logic                    busy;
	logic [COORD_W-1:0]      raw_x;
	logic [COORD_W-1:0]      raw_y;
	logic                    done;
	logic                    accepted;
	logic signed [REG_W-1:0] screen_x;
	logic signed [REG_W-1:0] screen_y;

	// Shadow copy of the register file, written in step with the config port.
	logic [REG_W-1:0] reg_shadow [8];

	// Mapped points still owed by the block, oldest first.
	screen_pt_t mapped_q [$];
	screen_pt_t want_pt;

	bit sending;
	bit no_gaps;
	int n_points;
	int n_results;
	int n_dropped;
	int n_settings;
	int n_errors;

	tablet_area_rotate_scale_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.raw_x     (raw_x),
		.raw_y     (raw_y),
		.done      (done),
		.accepted  (accepted),
		.screen_x  (screen_x),
		.screen_y  (screen_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops results.
	initial begin
		#2_000_000;
		$display("Timeout with %0d points still outstanding", mapped_q.size());
		$display("FAIL tablet_area_rotate_scale_map");
		$finish;
	end

	task automatic report_error(input string msg);
		n_errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Map one raw point with the shadow registers: passthrough, rotation about the
	// area centre, drop or clamp, per-axis scale and signed screen offset.
	function automatic screen_pt_t map_point(input logic [COORD_W-1:0] px,
	                                         input logic [COORD_W-1:0] py);
		screen_pt_t        r;
		logic [MODE_W-1:0] md;
		logic signed [TRIG_W-1:0] sin_f, cos_f;
		logic signed [COORD_W-1:0] off_x, off_y;
		longint            w, h, hw, hh, dx, dy, sn, cs, relx, rely;
		logic [63:0]       prod_x, prod_y;
		md    = reg_shadow[REG_MODE][MODE_W-1:0];
		w     = reg_shadow[REG_AREA_SIZE][15:0];
		h     = reg_shadow[REG_AREA_SIZE][31:16];
		if (md[MODE_PASS] || w == 0 || h == 0) begin
			r.accepted = 1'b1;
			r.sx       = REG_W'(px);
			r.sy       = REG_W'(py);
			return r;
		end
		hw    = w / 2;
		hh    = h / 2;
		dx    = longint'(px) - (longint'(reg_shadow[REG_AREA_ORIGIN][15:0]) + hw);
		dy    = longint'(py) - (longint'(reg_shadow[REG_AREA_ORIGIN][31:16]) + hh);
		sin_f = reg_shadow[REG_SIN_VALUE][TRIG_W-1:0];
		cos_f = reg_shadow[REG_COS_VALUE][TRIG_W-1:0];
		sn    = sin_f;
		cs    = cos_f;
		relx  = hw + ((dx * cs + dy * sn) >>> FRAC_BITS);
		rely  = hh + ((dy * cs - dx * sn) >>> FRAC_BITS);
		// Limiting wins over clamping: an outside point is dropped with zero coords.
		if (md[MODE_LIMIT] && (relx < 0 || relx > w || rely < 0 || rely > h)) begin
			r.accepted = 1'b0;
			r.sx       = '0;
			r.sy       = '0;
			return r;
		end
		if (md[MODE_CLIP]) begin
			if (relx < 0) relx = 0;
			if (relx > w) relx = w;
			if (rely < 0) rely = 0;
			if (rely > h) rely = h;
		end
		// Products wrap at 64 bits; keep the 32 bits just above the fraction.
		prod_x     = relx * reg_shadow[REG_SCALE_X];
		prod_y     = rely * reg_shadow[REG_SCALE_Y];
		off_x      = reg_shadow[REG_SCREEN_ORIGIN][15:0];
		off_y      = reg_shadow[REG_SCREEN_ORIGIN][31:16];
		r.accepted = 1'b1;
		r.sx       = prod_x[FRAC_BITS +: REG_W] + REG_W'(off_x);
		r.sy       = prod_y[FRAC_BITS +: REG_W] + REG_W'(off_y);
		return r;
	endfunction

	// Mostly back-to-back transfers, some short gaps, a few long ones.
	function automatic int pick_gap();
		int roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called at a falling edge; returns at a falling edge. Start stays high into
	// the next call when no gap is drawn, so back-to-back transfers need no dip.
	task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
		int gap;
		start   <= 1'b1;
		raw_x   <= px;
		raw_y   <= py;
		sending = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// Transfer happened at this edge: predict it with the current registers.
		mapped_q.push_back(map_point(px, py));
		n_points++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start   <= 1'b0;
			sending = 1'b0;
			raw_x   <= COORD_W'($urandom);
			raw_y   <= COORD_W'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop start, let every outstanding result come out, then give the pipe slack.
	task automatic wait_idle();
		if (sending) begin
			start   <= 1'b0;
			sending = 1'b0;
		end
		while (mapped_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_SLACK) @(negedge clk);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_wr_en       <= 1'b1;
		cfg_addr        <= idx;
		cfg_wdata       <= val;
		reg_shadow[idx] = val;
		@(negedge clk);
	endtask

	// Rewrite the whole register file while the pipeline is empty.
	task automatic set_config(input logic [MODE_W-1:0] md, input logic [REG_W-1:0] size,
	                          input logic [REG_W-1:0] origin, input logic [REG_W-1:0] sn,
	                          input logic [REG_W-1:0] cs, input logic [REG_W-1:0] scx,
	                          input logic [REG_W-1:0] scy, input logic [REG_W-1:0] so);
		wait_idle();
		put_reg(REG_MODE, REG_W'(md));
		put_reg(REG_AREA_SIZE, size);
		put_reg(REG_AREA_ORIGIN, origin);
		put_reg(REG_SIN_VALUE, sn);
		put_reg(REG_COS_VALUE, cs);
		put_reg(REG_SCALE_X, scx);
		put_reg(REG_SCALE_Y, scy);
		put_reg(REG_SCREEN_ORIGIN, so);
		cfg_wr_en <= 1'b0;
		// Shadow keeps only the bits the block stores.
		reg_shadow[REG_MODE]      = REG_W'(md);
		reg_shadow[REG_SIN_VALUE] = REG_W'(sn[TRIG_W-1:0]);
		reg_shadow[REG_COS_VALUE] = REG_W'(cs[TRIG_W-1:0]);
		n_settings++;
	endtask

	// Out of reset the area is zero-sized, so points pass straight through.
	task automatic test_reset_identity();
		send_point(16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF);
		send_point(16'h0000, 16'hFFFF);
		send_point(16'hFFFF, 16'h0000);
	endtask

	// Passthrough by mode bit (over limit and clamp), then by zero width and zero height.
	task automatic test_passthrough();
		set_config(M_PASS | M_LIMIT | M_CLIP, {16'd256, 16'd512}, {16'd16, 16'd32},
		           32'h0000_8000, 32'h0000_DDB4, 32'h0002_0000, 32'h0002_0000, 32'h1234_5678);
		send_point(16'd1234, 16'd4321);
		set_config(M_LIMIT, {16'd100, 16'd0}, {16'd0, 16'd0},
		           '0, ONE_Q, ONE_Q, ONE_Q, 32'h0010_0010);
		send_point(16'd7000, 16'd9);
		set_config(M_CLIP, {16'd0, 16'd100}, {16'd0, 16'd0},
		           '0, ONE_Q, ONE_Q, ONE_Q, 32'h0010_0010);
		send_point(16'd9, 16'd7000);
	endtask

	// Zero angle: relative coordinate is raw minus origin, no limiting so points
	// left of or above the area go negative through the scale product.
	task automatic test_zero_angle();
		set_config(M_NONE, {16'd800, 16'd1000}, {16'd200, 16'd100},
		           '0, ONE_Q, 32'h0002_0000, 32'h0000_8000, {16'h0010, 16'hFFF0});
		send_point(16'd100, 16'd200);
		send_point(16'd1100, 16'd1000);
		send_point(16'd600, 16'd600);
		send_point(16'd50, 16'd1500);
	endtask

	// Quarter turn with limiting: centre stays, a corner swings out and drops, as does a point beyond the area.
	task automatic test_limit();
		set_config(M_LIMIT, {16'd400, 16'd600}, {16'd1000, 16'd1000},
		           ONE_Q, '0, ONE_Q, ONE_Q, '0);
		send_point(16'd1300, 16'd1200);
		send_point(16'd1000, 16'd1000);
		send_point(16'd1300, 16'd1800);
	endtask

	// Clamp to both edges, then limit and clamp together where limiting decides.
	task automatic test_clamp();
		set_config(M_CLIP, {16'd400, 16'd600}, {16'd1000, 16'd1000},
		           '0, ONE_Q, 32'h0003_0000, 32'h0003_0000, 32'h0100_0100);
		send_point(16'd900, 16'd900);
		send_point(16'd2000, 16'd2000);
		send_point(16'd1100, 16'd1700);
		set_config(M_LIMIT | M_CLIP, {16'd400, 16'd600}, {16'd1000, 16'd1000},
		           '0, ONE_Q, 32'h0003_0000, 32'h0003_0000, 32'h0100_0100);
		send_point(16'd900, 16'd900);
	endtask

	// Register extremes: full-size area, out-of-range trig patterns used as given,
	// largest and zero scale, most negative screen offsets; then a 1x1 area with sine
	// and cosine both minus one and maximum scale.
	task automatic test_extremes();
		set_config(M_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0001_FFFF,
		           32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_8000);
		send_point(16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF);
		send_point(16'h0000, 16'hFFFF);
		send_point(16'hFFFF, 16'h0000);
		set_config(M_NONE, 32'h0001_0001, 32'h0000_0000, MINUS_ONE, MINUS_ONE,
		           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_7FFF);
		send_point(16'h0000, 16'h0000);
		send_point(16'h0001, 16'h0001);
	endtask

	// Random settings, each followed by a burst of points aimed mostly around the
	// active area so limit and clamp decisions go both ways.
	task automatic test_random();
		int                 n_items;
		int                 sel;
		logic [MODE_W-1:0]  md;
		logic [COORD_W-1:0] w, h, ox, oy, px, py;
		logic [REG_W-1:0]   sn, cs, scx, scy;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			md = MODE_W'($urandom_range(0, 7));
			if (md[MODE_PASS] && $urandom_range(0, 2) != 0)
				md[MODE_PASS] = 1'b0;
			sel = $urandom_range(0, 9);
			w   = (sel == 0) ? '0 : (sel == 1) ? '1 : COORD_W'($urandom_range(1, 20000));
			h   = (sel == 2) ? '0 : (sel == 1) ? '1 : COORD_W'($urandom_range(1, 20000));
			ox  = ($urandom_range(0, 7) == 0) ? '1 : COORD_W'($urandom);
			oy  = ($urandom_range(0, 7) == 0) ? '0 : COORD_W'($urandom);
			case ($urandom_range(0, 7))
				0: begin sn = '0;        cs = ONE_Q;     end
				1: begin sn = ONE_Q;     cs = '0;        end
				2: begin sn = '0;        cs = MINUS_ONE; end
				3: begin sn = MINUS_ONE; cs = '0;        end
				4: begin sn = $urandom;  cs = $urandom;  end
				default: begin
					sn = REG_W'(int'($urandom_range(0, 131072)) - 65536);
					cs = REG_W'(int'($urandom_range(0, 131072)) - 65536);
				end
			endcase
			case ($urandom_range(0, 6))
				0: begin scx = $urandom; scy = $urandom; end
				1: begin scx = '1;       scy = '0;       end
				2: begin scx = '0;       scy = '1;       end
				default: begin
					scx = $urandom_range(32'h0000_4000, 32'h0004_0000);
					scy = $urandom_range(32'h0000_4000, 32'h0004_0000);
				end
			endcase
			set_config(md, {h, w}, {oy, ox}, sn, cs, scx, scy, $urandom);
			// Some bursts run with no idle cycles at all.
			no_gaps = ($urandom_range(0, 3) == 0);
			n_items = $urandom_range(60, 100);
			repeat (n_items) begin
				if ($urandom_range(0, 9) < 7) begin
					px = COORD_W'(int'(ox) - int'(w) / 4 +
					              int'($urandom_range(0, int'(w) + int'(w) / 2)));
					py = COORD_W'(int'(oy) - int'(h) / 4 +
					              int'($urandom_range(0, int'(h) + int'(h) / 2)));
				end else begin
					px = COORD_W'($urandom);
					py = COORD_W'($urandom);
				end
				send_point(px, py);
			end
		end
		no_gaps = 1'b0;
	endtask

	// Check every result strobe against the oldest predicted point. Outputs are
	// read at the rising edge, before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (mapped_q.size() == 0) begin
				report_error("result strobe with no point outstanding");
			end else begin
				want_pt = mapped_q.pop_front();
				if (accepted !== want_pt.accepted)
					report_error($sformatf("result %0d: accepted got %b want %b",
					                       n_results, accepted, want_pt.accepted));
				if (screen_x !== want_pt.sx)
					report_error($sformatf("result %0d: screen_x got %h want %h",
					                       n_results, screen_x, want_pt.sx));
				if (screen_y !== want_pt.sy)
					report_error($sformatf("result %0d: screen_y got %h want %h",
					                       n_results, screen_y, want_pt.sy));
				if (!want_pt.accepted)
					n_dropped++;
			end
		end
	end

	initial begin
		// Hold every input at a known value through reset.
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr  = REG_MODE;
		cfg_wdata = '0;
		raw_x     = '0;
		raw_y     = '0;
		sending   = 1'b0;
		no_gaps   = 1'b0;
		foreach (reg_shadow[i])
			reg_shadow[i] = '0;
		reg_shadow[REG_COS_VALUE] = REG_W'(COS_RESET);
		reg_shadow[REG_SCALE_X]   = SCALE_RESET;
		reg_shadow[REG_SCALE_Y]   = SCALE_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_identity();
		test_passthrough();
		test_zero_angle();
		test_limit();
		test_clamp();
		test_extremes();
		test_random();

		// Drain the pipeline and let it settle.
		wait_idle();

		$display("Mapped %0d points over %0d register settings; %0d results checked",
		         n_points, n_settings, n_results);
		$display("%0d points dropped by area limiting, %0d mismatches", n_dropped, n_errors);
		if (n_errors == 0)
			$display("PASS tablet_area_rotate_scale_map");
		else
			$display("FAIL tablet_area_rotate_scale_map");
		$finish;
	end

endmodule

### files.f
src/tarsm_pkg.sv
src/tablet_area_rotate_scale_map.sv
bench/tb_tablet_area_rotate_scale_map.sv
